/* rtl/text_line_segmenter_defines.svh */
// Assertion macros shared by the text line segmenter RTL.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef TEXT_LINE_SEGMENTER_DEFINES_SVH
`define TEXT_LINE_SEGMENTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TLS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tls_pkg.sv */
// Types, constants and register codes for the text line segmenter.
// Depends on nothing; imported by every module of the block.
package tls_pkg;

    localparam int ROW_W      = 12;
    localparam int INK_W      = 12;
    localparam int LEVEL_W    = 10;
    localparam int COUNT_W    = 8;
    localparam int FROM_W     = 13;
    localparam int WIDTH_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int PRODUCT_W  = INK_W + LEVEL_W;
    localparam int STEP_W     = 4;

    localparam logic [ROW_W-1:0]   ROW_LAST  = '1;
    localparam logic [LEVEL_W-1:0] PER_MILLE = 10'd1000;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [COUNT_W-1:0] LINE_LIMIT_RESET = '1;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMN_HEIGHT   = 3'd0,
        CFG_COLUMN_WIDTH    = 3'd1,
        CFG_START_LEVEL     = 3'd2,
        CFG_END_LEVEL       = 3'd3,
        CFG_MIN_LINE_HEIGHT = 3'd4,
        CFG_LINE_GAP        = 3'd5,
        CFG_LINE_LIMIT      = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [ROW_W-1:0]   column_height;
        logic [WIDTH_W-1:0] column_width;
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] end_level;
        logic [ROW_W-1:0]   min_line_height;
        logic [ROW_W-1:0]   line_gap;
        logic [COUNT_W-1:0] line_limit;
    } cfg_t;

    typedef struct packed {
        logic             first_row;
        logic             beyond;
        logic [ROW_W-1:0] row;
        logic [INK_W-1:0] ink;
    } row_entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_DIV,
        B_APPLY
    } back_state_t;

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_ITER
    } div_state_t;

endpackage

/* rtl/tls_front.sv */
// Front end: accepts rows, tracks the row number and flags rows past the column.
// Depends on tls_pkg; feeds tls_queue.
module tls_front
    import tls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             first_row,
    input  logic [INK_W-1:0] ink_count,
    input  logic [ROW_W-1:0] column_height,
    input  logic             queue_full,
    output logic             push,
    output row_entry_t       push_data
);

    logic [ROW_W-1:0] row_cnt_reg;
    logic [ROW_W-1:0] row_cnt_next;
    logic [ROW_W-1:0] row;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;
    assign row      = first_row ? '0 : row_cnt_reg;

    always_comb
    begin
        row_cnt_next = row_cnt_reg;
        if (push)
        begin
            // saturate at the last row
            row_cnt_next = (row < ROW_LAST) ? row + 1'b1 : ROW_LAST;
        end
    end

    always_comb
    begin
        push_data.first_row = first_row;
        push_data.beyond    = (row >= column_height);
        push_data.row       = row;
        push_data.ink       = ink_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
        end
        else
        begin
            row_cnt_reg <= row_cnt_next;
        end
    end

endmodule

/* rtl/tls_queue.sv */
// Short row queue between the front end and the back end.
// Depends on tls_pkg for the entry type.
module tls_queue
    import tls_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  row_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output row_entry_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    row_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/tls_divider.sv */
// Per-mille scaling unit: 1000 * ink / width, saturated to the level range.
// Depends on tls_pkg; restoring division, one quotient bit per cycle.
module tls_divider
    import tls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [INK_W-1:0]   ink,
    input  logic [WIDTH_W-1:0] width,
    output logic               done,
    output logic [LEVEL_W-1:0] level
);

    div_state_t           state_reg;
    div_state_t           state_next;
    logic [PRODUCT_W-1:0] product_reg;
    logic [PRODUCT_W-1:0] product_next;
    logic [WIDTH_W-1:0]   width_reg;
    logic [WIDTH_W-1:0]   width_next;
    logic [WIDTH_W-1:0]   rem_reg;
    logic [WIDTH_W-1:0]   rem_next;
    logic [LEVEL_W-1:0]   quot_reg;
    logic [LEVEL_W-1:0]   quot_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 done_reg;
    logic                 done_next;
    logic [WIDTH_W:0]     trial;

    assign done  = done_reg;
    assign level = quot_reg;
    assign trial = {rem_reg, product_reg[LEVEL_W-1]};

    always_comb
    begin
        state_next   = state_reg;
        product_next = product_reg;
        width_next   = width_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        step_next    = step_reg;
        done_next    = 1'b0;
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    product_next = PRODUCT_W'(ink) * PRODUCT_W'(PER_MILLE);
                    width_next   = width;
                    state_next   = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // quotient would not fit the level range: saturate
                if (product_reg >= {width_reg, {LEVEL_W{1'b0}}})
                begin
                    quot_next  = LEVEL_MAX;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = product_reg[PRODUCT_W-1:LEVEL_W];
                    quot_next  = '0;
                    step_next  = '0;
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                product_next = {product_reg[PRODUCT_W-2:0], 1'b0};
                if (trial >= {1'b0, width_reg})
                begin
                    rem_next  = WIDTH_W'(trial - {1'b0, width_reg});
                    quot_next = {quot_reg[LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial[WIDTH_W-1:0];
                    quot_next = {quot_reg[LEVEL_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(LEVEL_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
        width_reg   <= width_next;
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
    end

endmodule

/* rtl/tls_back.sv */
// Back end: line search state, level scaling control and the result register.
// Depends on tls_pkg, tls_divider and the assertion macros header.
`include "text_line_segmenter_defines.svh"

module tls_back
    import tls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               queue_empty,
    output logic               queue_pop,
    input  row_entry_t         queue_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ROW_W-1:0]   line_top,
    output logic [ROW_W-1:0]   line_bottom,
    output logic [COUNT_W-1:0] line_index
);

    back_state_t        state_reg;
    back_state_t        state_next;
    row_entry_t         entry_reg;
    row_entry_t         entry_next;
    logic [LEVEL_W-1:0] lv_reg;
    logic [LEVEL_W-1:0] lv_next;
    logic               inside_reg;
    logic               inside_next;
    logic [ROW_W-1:0]   open_top_reg;
    logic [ROW_W-1:0]   open_top_next;
    logic [LEVEL_W-1:0] prev_reg;
    logic [LEVEL_W-1:0] prev_next;
    logic [COUNT_W-1:0] lines_reg;
    logic [COUNT_W-1:0] lines_next;
    logic [FROM_W-1:0]  search_from_reg;
    logic [FROM_W-1:0]  search_from_next;
    logic               search_done_reg;
    logic               search_done_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [ROW_W-1:0]   line_top_reg;
    logic [ROW_W-1:0]   line_top_next;
    logic [ROW_W-1:0]   line_bottom_reg;
    logic [ROW_W-1:0]   line_bottom_next;
    logic [COUNT_W-1:0] line_index_reg;
    logic [COUNT_W-1:0] line_index_next;

    logic               div_start;
    logic               div_done;
    logic [LEVEL_W-1:0] div_level;
    logic               close_ok;
    logic [COUNT_W-1:0] lines_inc;

    tls_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .ink   (entry_reg.ink),
        .width (cfg.column_width),
        .done  (div_done),
        .level (div_level)
    );

    assign out_valid   = out_valid_reg;
    assign line_top    = line_top_reg;
    assign line_bottom = line_bottom_reg;
    assign line_index  = line_index_reg;
    assign lines_inc   = lines_reg + 1'b1;

    assign close_ok = inside_reg && (lv_reg <= cfg.end_level)
                   && ((entry_reg.row - open_top_reg) > cfg.min_line_height)
                   && (lv_reg >= prev_reg);

    always_comb
    begin
        state_next       = state_reg;
        entry_next       = entry_reg;
        lv_next          = lv_reg;
        inside_next      = inside_reg;
        open_top_next    = open_top_reg;
        prev_next        = prev_reg;
        lines_next       = lines_reg;
        search_from_next = search_from_reg;
        search_done_next = search_done_reg;
        out_valid_next   = out_valid_reg && out_stall;
        line_top_next    = line_top_reg;
        line_bottom_next = line_bottom_reg;
        line_index_next  = line_index_reg;
        queue_pop        = 1'b0;
        div_start        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    queue_pop  = 1'b1;
                    entry_next = queue_data;
                    // new column: restart the search
                    if (queue_data.first_row)
                    begin
                        inside_next      = 1'b0;
                        open_top_next    = '0;
                        prev_next        = '0;
                        lines_next       = '0;
                        search_from_next = '0;
                        search_done_next = 1'b0;
                    end
                    state_next = B_CHECK;
                end
            end
            B_CHECK:
            begin
                if (entry_reg.beyond || search_done_reg || (lines_reg >= cfg.line_limit))
                begin
                    search_done_next = 1'b1;
                    state_next       = B_IDLE;
                end
                else if ({1'b0, entry_reg.row} < search_from_reg)
                begin
                    state_next = B_IDLE;
                end
                else if (cfg.column_width == '0)
                begin
                    lv_next = (entry_reg.ink > INK_W'(LEVEL_MAX)) ? LEVEL_MAX
                                                                  : entry_reg.ink[LEVEL_W-1:0];
                    state_next = B_APPLY;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    lv_next    = div_level;
                    state_next = B_APPLY;
                end
            end
            B_APPLY:
            begin
                if (close_ok)
                begin
                    // hold until the result register is free
                    if (!(out_valid_reg && out_stall))
                    begin
                        out_valid_next   = 1'b1;
                        line_top_next    = open_top_reg;
                        line_bottom_next = entry_reg.row;
                        line_index_next  = lines_reg;
                        lines_next       = lines_inc;
                        inside_next      = 1'b0;
                        prev_next        = '0;
                        search_from_next = FROM_W'({1'b0, entry_reg.row} + {1'b0, cfg.line_gap});
                        if (lines_inc >= cfg.line_limit)
                        begin
                            search_done_next = 1'b1;
                        end
                        else if (cfg.line_gap == '0)
                        begin
                            if (lv_reg >= cfg.start_level)
                            begin
                                open_top_next = entry_reg.row;
                                inside_next   = 1'b1;
                            end
                            prev_next = lv_reg;
                        end
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    if (!inside_reg && (lv_reg >= cfg.start_level))
                    begin
                        open_top_next = entry_reg.row;
                        inside_next   = 1'b1;
                    end
                    prev_next  = lv_reg;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            inside_reg      <= 1'b0;
            open_top_reg    <= '0;
            prev_reg        <= '0;
            lines_reg       <= '0;
            search_from_reg <= '0;
            search_done_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            inside_reg      <= inside_next;
            open_top_reg    <= open_top_next;
            prev_reg        <= prev_next;
            lines_reg       <= lines_next;
            search_from_reg <= search_from_next;
            search_done_reg <= search_done_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg       <= entry_next;
        lv_reg          <= lv_next;
        line_top_reg    <= line_top_next;
        line_bottom_reg <= line_bottom_next;
        line_index_reg  <= line_index_next;
    end

    `TLS_ASSERT_IMPL(a_div_done_while_waiting, div_done, state_reg == B_DIV,
                     "divider finished while back end was not waiting")
    `TLS_ASSERT_IMPL(a_line_ordered, out_valid_reg, line_bottom_reg > line_top_reg,
                     "reported line bottom not below its top")
    `TLS_ASSERT_NEXT(a_beyond_ends_search, state_reg == B_CHECK && entry_reg.beyond,
                     search_done_reg && state_reg == B_IDLE,
                     "row past the column did not end the search")

endmodule

/* rtl/text_line_segmenter.sv */
// Text line segmenter: finds text lines in a column from per-row ink counts and reports
// each line's top row, bottom row and ordinal. In the back end a skipped row (past the
// column, search finished or inside a gap) goes from the check state back to idle; at a
// zero column width the level is the ink count, saturated; otherwise the per-mille scaling
// is a restoring divider that yields one quotient bit per cycle over ten steps, with a
// range check before them that may saturate the level and a hand-off after. A closing row
// also waits for as long as an earlier result is stalled. A queue of QUEUE_DEPTH rows lets
// the input keep transferring while the back end works or waits on a stalled result; write
// registers only while no row is in flight. There is no clearing pass after reset.
module text_line_segmenter
    import tls_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  first_row,
    input  logic [INK_W-1:0]      ink_count,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ROW_W-1:0]      line_top,
    output logic [ROW_W-1:0]      line_bottom,
    output logic [COUNT_W-1:0]    line_index
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_empty;
    row_entry_t  push_data;
    row_entry_t  pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLUMN_HEIGHT:   cfg_next.column_height   = cfg_wdata[ROW_W-1:0];
                CFG_COLUMN_WIDTH:    cfg_next.column_width    = cfg_wdata[WIDTH_W-1:0];
                CFG_START_LEVEL:     cfg_next.start_level     = cfg_wdata[LEVEL_W-1:0];
                CFG_END_LEVEL:       cfg_next.end_level       = cfg_wdata[LEVEL_W-1:0];
                CFG_MIN_LINE_HEIGHT: cfg_next.min_line_height = cfg_wdata[ROW_W-1:0];
                CFG_LINE_GAP:        cfg_next.line_gap        = cfg_wdata[ROW_W-1:0];
                CFG_LINE_LIMIT:      cfg_next.line_limit      = cfg_wdata[COUNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.column_height   <= '0;
            cfg_reg.column_width    <= '0;
            cfg_reg.start_level     <= '0;
            cfg_reg.end_level       <= '0;
            cfg_reg.min_line_height <= '0;
            cfg_reg.line_gap        <= '0;
            cfg_reg.line_limit      <= LINE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tls_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .first_row     (first_row),
        .ink_count     (ink_count),
        .column_height (cfg_reg.column_height),
        .queue_full    (q_full),
        .push          (q_push),
        .push_data     (push_data)
    );

    tls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (pop_data)
    );

    tls_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .queue_empty (q_empty),
        .queue_pop   (q_pop),
        .queue_data  (pop_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_top    (line_top),
        .line_bottom (line_bottom),
        .line_index  (line_index)
    );

endmodule

/* tb/tb_text_line_segmenter.sv */
// Self-checking testbench for text_line_segmenter: drives pixel rows and register writes,
// predicts each reported line in a small tracker class and checks every result transfer.
// Depends on tls_pkg and the text_line_segmenter RTL.
module tb_text_line_segmenter
    import tls_pkg::*;
();

    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ROWS   = 1700;

    typedef struct {
        logic [ROW_W-1:0]   top;
        logic [ROW_W-1:0]   bottom;
        logic [COUNT_W-1:0] index;
    } line_t;

    class line_tracker;
        cfg_t               settings;
        logic [ROW_W-1:0]   row_number;
        logic [FROM_W-1:0]  search_from;
        logic               in_line;
        logic [ROW_W-1:0]   open_top;
        logic [LEVEL_W-1:0] previous_level;
        logic [COUNT_W-1:0] lines_found;
        logic               search_done;
        line_t              lines_due[$];
        int                 errors;

        function new();
            settings = '0;
            settings.line_limit = LINE_LIMIT_RESET;
            errors = 0;
            restart_column();
        endfunction

        function void restart_column();
            row_number = '0;
            search_from = '0;
            in_line = 1'b0;
            open_top = '0;
            previous_level = '0;
            lines_found = '0;
            search_done = 1'b0;
        endfunction

        function void open_if_level(logic [ROW_W-1:0] y, logic [LEVEL_W-1:0] lv);
            if (!in_line && lv >= settings.start_level)
            begin
                open_top = y;
                in_line = 1'b1;
            end
        endfunction

        function int pending();
            return lines_due.size();
        endfunction

        function void take_row(logic first, logic [INK_W-1:0] ink);
            logic [ROW_W-1:0]   y;
            logic [LEVEL_W-1:0] lv;
            int unsigned        scaled;
            line_t              found;
            if (first)
                restart_column();
            y = row_number;
            if (row_number != ROW_LAST)
                row_number = row_number + 1'b1;
            if (y >= settings.column_height || search_done
                || lines_found >= settings.line_limit)
            begin
                search_done = 1'b1;
                return;
            end
            if ({1'b0, y} < search_from)
                return;
            scaled = 32'(ink);
            if (settings.column_width != 0)
                scaled = (32'(PER_MILLE) * 32'(ink)) / 32'(settings.column_width);
            lv = (scaled > LEVEL_MAX) ? LEVEL_MAX : scaled[LEVEL_W-1:0];
            if (in_line && lv <= settings.end_level && lv >= previous_level
                && (y - open_top) > settings.min_line_height)
            begin
                found.top = open_top;
                found.bottom = y;
                found.index = lines_found;
                lines_due.push_back(found);
                lines_found = lines_found + 1'b1;
                in_line = 1'b0;
                previous_level = '0;
                search_from = {1'b0, y} + {1'b0, settings.line_gap};
                if (lines_found >= settings.line_limit)
                begin
                    search_done = 1'b1;
                    return;
                end
                if (settings.line_gap == 0)
                begin
                    open_if_level(y, lv);
                    previous_level = lv;
                end
                return;
            end
            open_if_level(y, lv);
            previous_level = lv;
        endfunction

        function void flag(string what, int want, int got);
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        endfunction

        function void match_line(logic [ROW_W-1:0] top, logic [ROW_W-1:0] bottom,
                                 logic [COUNT_W-1:0] index);
            line_t want;
            if (lines_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected line expected none, got top %0d bottom %0d index %0d",
                         $time, top, bottom, index);
                return;
            end
            want = lines_due.pop_front();
            if (want.top !== top)
                flag("line_top", int'(want.top), int'(top));
            if (want.bottom !== bottom)
                flag("line_bottom", int'(want.bottom), int'(bottom));
            if (want.index !== index)
                flag("line_index", int'(want.index), int'(index));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = CFG_COLUMN_HEIGHT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  first_row = 1'b0;
    logic [INK_W-1:0]      ink_count = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [ROW_W-1:0]      line_top;
    logic [ROW_W-1:0]      line_bottom;
    logic [COUNT_W-1:0]    line_index;

    line_tracker tracker = new();
    bit          tx_idling = 1'b1;
    bit          rx_idling = 1'b1;
    bit          hold_request = 1'b0;
    int          rows_sent = 0;
    int          quiet_cycles = 0;

    text_line_segmenter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_row   (first_row),
        .ink_count   (ink_count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_top    (line_top),
        .line_bottom (line_bottom),
        .line_index  (line_index)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 60);
    endfunction

    function automatic cfg_t make_settings(int height, int width, int start, int stop,
                                           int min_height, int gap, int most);
        cfg_t s;
        s.column_height = ROW_W'(height);
        s.column_width = WIDTH_W'(width);
        s.start_level = LEVEL_W'(start);
        s.end_level = LEVEL_W'(stop);
        s.min_line_height = ROW_W'(min_height);
        s.line_gap = ROW_W'(gap);
        s.line_limit = COUNT_W'(most);
        return s;
    endfunction

    function automatic cfg_t random_settings();
        cfg_t s;
        int   pick;
        s.column_height = ROW_W'($urandom_range(24, 90));
        pick = $urandom_range(0, 9);
        s.column_width = WIDTH_W'((pick < 2) ? 0 : (pick == 2) ? 4095 : $urandom_range(8, 600));
        if ($urandom_range(0, 3) == 0)
        begin
            s.start_level = LEVEL_W'($urandom_range(20, 80));
            s.end_level = LEVEL_W'($urandom_range(100, 300));
        end
        else
        begin
            s.start_level = LEVEL_W'($urandom_range(150, 800));
            s.end_level = LEVEL_W'($urandom_range(0, 200));
        end
        s.min_line_height = ROW_W'($urandom_range(0, 6));
        s.line_gap = ROW_W'(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
        s.line_limit = COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 255);
        return s;
    endfunction

    // ink count that lands on the given level at the current width
    function automatic logic [INK_W-1:0] ink_for_level(int unsigned level, bit round_up);
        int unsigned w;
        int unsigned ink;
        w = 32'(tracker.settings.column_width);
        if (w == 0)
            ink = level;
        else if (round_up)
            ink = (level * w + 32'(PER_MILLE) - 1) / 32'(PER_MILLE);
        else
            ink = level * w / 32'(PER_MILLE);
        return (ink > 4095) ? '1 : ink[INK_W-1:0];
    endfunction

    task automatic put_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    task automatic apply_settings(cfg_t s);
        put_register(CFG_COLUMN_HEIGHT, s.column_height);
        put_register(CFG_COLUMN_WIDTH, s.column_width);
        put_register(CFG_START_LEVEL, CFG_DATA_W'(s.start_level));
        put_register(CFG_END_LEVEL, CFG_DATA_W'(s.end_level));
        put_register(CFG_MIN_LINE_HEIGHT, s.min_line_height);
        put_register(CFG_LINE_GAP, s.line_gap);
        put_register(CFG_LINE_LIMIT, CFG_DATA_W'(s.line_limit));
        cfg_we <= 1'b0;
        tracker.settings = s;
    endtask

    task automatic send_row(logic first, logic [INK_W-1:0] ink);
        int gap;
        gap = tx_idling ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        first_row <= first;
        ink_count <= ink;
        do
            @(posedge clk);
        while (in_stall);
        rows_sent++;
        @(negedge clk);
    endtask

    // drop valid and hold until every line has come back
    task automatic settle(int extra);
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic send_column(int length, int pause_row);
        int               k;
        int               stretch;
        bit               text;
        logic [INK_W-1:0] ink;
        text = 1'b0;
        stretch = $urandom_range(1, 4);
        for (k = 0; k < length; k++)
        begin
            if (k == pause_row)
                settle(0);
            if (stretch == 0)
            begin
                text = !text;
                stretch = text ? $urandom_range(2, 8) : $urandom_range(1, 5);
            end
            stretch--;
            if ($urandom_range(0, 9) == 0)
                ink = INK_W'($urandom_range(0, 4095));
            else if (text)
                ink = ink_for_level($urandom_range(tracker.settings.start_level, 1023), 1'b1);
            else
                ink = ink_for_level($urandom_range(0, tracker.settings.end_level), 1'b0);
            send_row(k == 0 || $urandom_range(0, 149) == 0, ink);
        end
    endtask

    initial
    begin : result_sink
        int span;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!rx_idling)
            begin
                out_stall <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 3) == 0);
                span = 1 + gap_length();
                repeat (span) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
            tracker.take_row(first_row, ink_count);
        if (out_valid && !out_stall)
            tracker.match_line(line_top, line_bottom, line_index);
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        cfg_t plan;
        int   phase;
        int   k;
        int   columns;
        int   length;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // overflowing level, refused close on a falling level, rows past the column
        apply_settings(make_settings(10, 100, 300, 100, 1, 0, 255));
        send_row(1'b1, 12'd0);
        send_row(1'b0, 12'd4095);
        send_row(1'b0, 12'd40);
        send_row(1'b0, 12'd10);
        send_row(1'b0, 12'd10);
        send_row(1'b0, 12'd30);
        send_row(1'b0, 12'd0);
        send_row(1'b0, 12'd0);
        send_row(1'b0, 12'd4095);
        send_row(1'b0, 12'd0);
        send_row(1'b0, 12'd0);
        send_row(1'b0, 12'd0);
        settle(SETTLE_CYCLES);

        // zero width, reopen on the closing row, line limit
        apply_settings(make_settings(4095, 0, 50, 100, 0, 0, 2));
        send_row(1'b1, 12'd4095);
        send_row(1'b0, 12'd80);
        send_row(1'b0, 12'd80);
        send_row(1'b0, 12'd90);
        send_row(1'b0, 12'd500);
        settle(SETTLE_CYCLES);

        // no lines allowed
        apply_settings(make_settings(4095, 4095, 0, 1000, 0, 4095, 0));
        send_row(1'b1, 12'd4095);
        send_row(1'b0, 12'd2048);
        settle(SETTLE_CYCLES);

        // empty column
        apply_settings(make_settings(0, 1, 0, 0, 0, 0, 255));
        send_row(1'b1, 12'd1);
        send_row(1'b0, 12'd4095);
        settle(SETTLE_CYCLES);

        phase = 0;
        while (rows_sent < RANDOM_ROWS)
        begin
            case (phase)
                1: plan = make_settings(4095, 4095, 1000, 1000, 4095, 4095, 255);
                2: plan = make_settings(4095, 0, 0, 0, 0, 0, 255);
                default: plan = random_settings();
            endcase
            tx_idling = (phase % 3 != 0);
            rx_idling = (phase % 4 != 1);
            apply_settings(plan);
            columns = $urandom_range(2, 4);
            for (k = 0; k < columns; k++)
            begin
                if (plan.column_height > 120)
                    length = $urandom_range(30, 60);
                else
                    length = plan.column_height + $urandom_range(0, 6) - 3;
                if (phase == 3 && k == 0)
                    hold_request = 1'b1;
                send_column(length, (phase == 5 && k == 1) ? length / 2 : -1);
            end
            settle(SETTLE_CYCLES);
            phase++;
        end

        if (tracker.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
